FILE: src/rmq_pkg.sv
// Shared constants and codes for the rotation-matrix-to-quaternion block.
`timescale 1ns / 1ps
package rmq_pkg;
    localparam int FRAC_BITS_DEF = 14;
    localparam int ELEM_W        = 16;
    localparam int NUM_ELEM      = 9;
    localparam int NUM_Q         = 4;
    localparam int K_BITS        = 16;
    localparam int S_DATA_W      = NUM_ELEM * ELEM_W;
    localparam int M_DATA_W      = NUM_Q * ELEM_W;

    // Which quaternion component carries the pivot.
    typedef enum logic [1:0] {
        PIV_X,
        PIV_Y,
        PIV_Z,
        PIV_W
    } piv_t;
endpackage

FILE: src/rotation_matrix_to_quaternion.sv
// Pipelined Shepperd rotation-matrix-to-quaternion converter.
`timescale 1ns / 1ps
// Stages: front stage, setup stage, 16 result-bit stages, output register.
// Throughput: one request per cycle unless the output stalls; each result bit of all
//   four components is settled by one shift-add-compare stage, so the 16 stages set the depth.
// Stalls collapse bubbles: a stage loads whenever it is empty or moves on.
// Reset (aresetn low, synchronous) clears all valid bits; data is not reset.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // s_tdata, low to high: e_r0c0, e_r1c0, e_r2c0, e_r0c1, e_r1c1, e_r2c1,
    //   e_r0c2, e_r1c2, e_r2c2 (16 bits each)
    input  logic [rmq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // m_tdata, low to high: quat_x, quat_y, quat_z, quat_w (16 bits each)
    output logic [rmq_pkg::M_DATA_W-1:0] m_tdata,
    // m_tuser: degenerate
    output logic [0:0]                   m_tuser
);
    import rmq_pkg::*;

    // t spans one +/- three element magnitudes; keep sign plus headroom.
    localparam int TW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
    localparam int TU  = TW - 1;
    localparam int CW  = ELEM_W + 1;
    localparam int MW  = ELEM_W + 1;
    localparam int RW  = 2 * MW + FRAC_BITS;
    localparam int WW  = 2 * (K_BITS + 1) + TU + 4;
    localparam int NIT = K_BITS;
    localparam logic [K_BITS:0] LIM_POS = (K_BITS + 1)'((1 << (K_BITS - 1)) - 1);
    localparam logic [K_BITS:0] LIM_NEG = (K_BITS + 1)'(1 << (K_BITS - 1));

    typedef struct packed {
        logic [NUM_Q-1:0][CW-1:0] comp;
        logic [TW-1:0]            t;
        piv_t                     piv;
    } front_t;

    typedef struct packed {
        logic          neg;
        logic          lim_hi;
        logic          piv_lane;
        logic [RW-1:0] rhs;
        logic [WW-1:0] p;      // d^2 * tl for the current candidate
        logic [WW-1:0] d;      // d * tl, d = 2k-1
        logic [K_BITS-1:0] k;
    } lane_t;

    typedef struct packed {
        lane_t [NUM_Q-1:0] lane;
        logic [TU-1:0]     t;
        logic              degen;
    } item_t;

    logic   a_valid_reg;
    front_t a_reg, a_next;
    logic   [NIT:0] p_valid_reg;
    item_t  pipe_reg  [NIT+1];
    item_t  pipe_next [NIT+1];
    logic   m_valid_reg;
    logic   [M_DATA_W-1:0] m_data_reg, m_data_next;
    logic   m_user_reg;

    logic          ce_a, ce_o;
    logic [NIT:0]  ce_p;

    // Ready chain: a stage takes a request when empty or when it moves on.
    always_comb begin
        ce_o = !m_valid_reg || m_tready;
        ce_p[NIT] = !p_valid_reg[NIT] || ce_o;
        for (int i = NIT - 1; i >= 0; i--) begin
            ce_p[i] = !p_valid_reg[i] || ce_p[i+1];
        end
        ce_a = !a_valid_reg || ce_p[0];
    end

    assign s_tready = ce_a;

    // Front stage: branch select, pivot and off-diagonal sums.
    logic signed [ELEM_W-1:0] e [NUM_ELEM];
    logic signed [CW-1:0] s10, d10, s02, d02, s21, d21, sab;
    logic signed [TW-1:0] t_one, ta, tb, tc;

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            e[i] = s_tdata[i*ELEM_W +: ELEM_W];
        end
        s10 = CW'(e[1]) + CW'(e[3]);
        d10 = CW'(e[1]) - CW'(e[3]);
        s02 = CW'(e[6]) + CW'(e[2]);
        d02 = CW'(e[6]) - CW'(e[2]);
        s21 = CW'(e[5]) + CW'(e[7]);
        d21 = CW'(e[5]) - CW'(e[7]);
        sab = CW'(e[0]) + CW'(e[4]);
        t_one = TW'(1) <<< FRAC_BITS;
        ta = TW'(e[0]);
        tb = TW'(e[4]);
        tc = TW'(e[8]);
        a_next = '0;
        if (e[8] < 0) begin
            if (e[0] > e[4]) begin
                a_next.piv  = PIV_X;
                a_next.t    = t_one + ta - tb - tc;
                a_next.comp[1] = s10;
                a_next.comp[2] = s02;
                a_next.comp[3] = d21;
            end else begin
                a_next.piv  = PIV_Y;
                a_next.t    = t_one - ta + tb - tc;
                a_next.comp[0] = s10;
                a_next.comp[2] = s21;
                a_next.comp[3] = d02;
            end
        end else begin
            if (sab < 0) begin
                a_next.piv  = PIV_Z;
                a_next.t    = t_one - ta - tb + tc;
                a_next.comp[0] = s02;
                a_next.comp[1] = s21;
                a_next.comp[3] = d10;
            end else begin
                a_next.piv  = PIV_W;
                a_next.t    = t_one + ta + tb + tc;
                a_next.comp[0] = d21;
                a_next.comp[1] = d02;
                a_next.comp[2] = d10;
            end
        end
    end

    // Setup stage: magnitudes, squared right-hand sides, search start (k = 0).
    logic signed [CW-1:0] c_s [NUM_Q];
    logic [MW-1:0]        mag [NUM_Q];
    logic [WW-1:0]        tl0 [NUM_Q];
    item_t                setup_next;

    always_comb begin
        setup_next.t     = a_reg.t[TU-1:0];
        setup_next.degen = ($signed(a_reg.t) <= 0);
        for (int l = 0; l < NUM_Q; l++) begin
            c_s[l] = $signed(a_reg.comp[l]);
            mag[l] = (c_s[l] < 0) ? MW'(-(CW + 1)'(c_s[l])) : MW'(c_s[l]);
            setup_next.lane[l].piv_lane = (int'(a_reg.piv) == l);
            if (int'(a_reg.piv) == l) begin
                tl0[l] = WW'(1);
                setup_next.lane[l].neg    = 1'b0;
                setup_next.lane[l].lim_hi = 1'b0;
                setup_next.lane[l].rhs    = RW'(a_reg.t[TU-1:0]) << FRAC_BITS;
            end else begin
                tl0[l] = WW'(a_reg.t[TU-1:0]);
                setup_next.lane[l].neg    = (c_s[l] < 0);
                setup_next.lane[l].lim_hi = (c_s[l] < 0);
                setup_next.lane[l].rhs    = (RW'(mag[l]) * RW'(mag[l])) << FRAC_BITS;
            end
            setup_next.lane[l].p = tl0[l];
            setup_next.lane[l].d = -tl0[l];
            setup_next.lane[l].k = '0;
        end
    end

    // Result-bit stages: try setting bit j of k; d grows by 2^(j+1).
    logic [WW-1:0]       tl   [NIT][NUM_Q];
    logic signed [WW-1:0] cand [NIT][NUM_Q];
    logic [K_BITS-1:0]   kc   [NIT][NUM_Q];

    always_comb begin
        pipe_next[0] = setup_next;
        for (int i = 0; i < NIT; i++) begin
            pipe_next[i+1] = pipe_reg[i];
            for (int l = 0; l < NUM_Q; l++) begin
                tl[i][l] = pipe_reg[i].lane[l].piv_lane ? WW'(1) : WW'(pipe_reg[i].t);
                cand[i][l] = $signed(pipe_reg[i].lane[l].p)
                           + ($signed(pipe_reg[i].lane[l].d) <<< (NIT - 1 - i + 2))
                           + $signed(tl[i][l] << (2 * (NIT - 1 - i) + 2));
                kc[i][l] = pipe_reg[i].lane[l].k | (K_BITS'(1) << (NIT - 1 - i));
                if ((cand[i][l] <= $signed(WW'(pipe_reg[i].lane[l].rhs)))
                        && ({1'b0, kc[i][l]} <= (pipe_reg[i].lane[l].lim_hi ?
                                                  LIM_NEG : LIM_POS))) begin
                    pipe_next[i+1].lane[l].p = cand[i][l];
                    pipe_next[i+1].lane[l].d = pipe_reg[i].lane[l].d
                                             + (tl[i][l] << (NIT - 1 - i + 1));
                    pipe_next[i+1].lane[l].k = kc[i][l];
                end
            end
        end
    end

    // Output stage: apply sign, zero a degenerate request.
    always_comb begin
        for (int l = 0; l < NUM_Q; l++) begin
            if (pipe_reg[NIT].degen) begin
                m_data_next[l*ELEM_W +: ELEM_W] = '0;
            end else if (pipe_reg[NIT].lane[l].neg) begin
                m_data_next[l*ELEM_W +: ELEM_W] = ELEM_W'(-pipe_reg[NIT].lane[l].k);
            end else begin
                m_data_next[l*ELEM_W +: ELEM_W] = ELEM_W'(pipe_reg[NIT].lane[l].k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            p_valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ce_a) begin
                a_valid_reg <= s_tvalid;
            end
            if (ce_p[0]) begin
                p_valid_reg[0] <= a_valid_reg;
            end
            for (int i = 1; i <= NIT; i++) begin
                if (ce_p[i]) begin
                    p_valid_reg[i] <= p_valid_reg[i-1];
                end
            end
            if (ce_o) begin
                m_valid_reg <= p_valid_reg[NIT];
            end
        end
        if (ce_a) begin
            a_reg <= a_next;
        end
        for (int i = 0; i <= NIT; i++) begin
            if (ce_p[i]) begin
                pipe_reg[i] <= pipe_next[i];
            end
        end
        if (ce_o) begin
            m_data_reg <= m_data_next;
            m_user_reg <= pipe_reg[NIT].degen;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_user_reg;

    // Hold only when the output is blocked.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A degenerate result carries zero components.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("degenerate result with nonzero data");

    // Nothing leaves right after reset.
    assert property (@(posedge aclk) (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("output valid right after reset");

    // Exactly one lane carries the pivot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        p_valid_reg[0] |-> ($countones({pipe_reg[0].lane[0].piv_lane,
                                          pipe_reg[0].lane[1].piv_lane,
                                          pipe_reg[0].lane[2].piv_lane,
                                          pipe_reg[0].lane[3].piv_lane}) == 1))
        else $error("pivot lane not unique");
endmodule

FILE: dv/tb_rotation_matrix_to_quaternion.sv
// Self-checking testbench for the rotation-matrix-to-quaternion converter.
`timescale 1ns / 1ps
module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int N_RANDOM   = 1068;
    localparam int LATENCY    = 19;
    localparam int MAX_CYCLES = 400000;
    localparam int N_DIRECTED = 22;

    typedef struct packed {
        logic signed [15:0] r2c2, r1c2, r0c2, r2c1, r1c1, r0c1, r2c0, r1c0, r0c0;
    } matrix_t;

    typedef struct {
        logic signed [15:0] q [4];
        logic               degen;
    } quat_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [0:0]            m_tuser;

    quat_t   quat_expected_q[$];
    int      error_count = 0;
    int      result_count = 0;
    int      degen_count = 0;
    int      cycle_count = 0;
    bit      stim_done = 1'b0;
    bit      long_hold = 1'b0;
    int      branch_hits[4] = '{0, 0, 0, 0};

    matrix_t dir_mat[N_DIRECTED];
    bit      dir_has_exp[N_DIRECTED];
    quat_t   dir_exp[N_DIRECTED];

    rotation_matrix_to_quaternion #(.FRAC_BITS(FB)) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Largest k in [0, lim] with k == 0 or (2k-1)^2 * t <= rhs.
    function automatic longint unsigned round_root(longint unsigned t, longint unsigned rhs,
                                                   longint unsigned lim);
        longint unsigned lo, hi, mid, d;
        lo = 0;
        hi = lim;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            d = 2 * mid - 1;
            if (d * d * t <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    // Compute the quaternion for one matrix; tally the chosen branch.
    function automatic quat_t matrix_to_quat(matrix_t m);
        quat_t r;
        longint one, a, b, c, t, mag, k;
        longint comp[4];
        piv_t piv;
        one = longint'(1) << FB;
        a = m.r0c0;
        b = m.r1c1;
        c = m.r2c2;
        if (c < 0) begin
            if (a > b) begin
                piv = PIV_X;
                t = one + a - b - c;
                comp[1] = m.r1c0 + m.r0c1;
                comp[2] = m.r0c2 + m.r2c0;
                comp[3] = m.r2c1 - m.r1c2;
            end else begin
                piv = PIV_Y;
                t = one - a + b - c;
                comp[0] = m.r1c0 + m.r0c1;
                comp[2] = m.r2c1 + m.r1c2;
                comp[3] = m.r0c2 - m.r2c0;
            end
        end else begin
            if (a < -b) begin
                piv = PIV_Z;
                t = one - a - b + c;
                comp[0] = m.r0c2 + m.r2c0;
                comp[1] = m.r2c1 + m.r1c2;
                comp[3] = m.r1c0 - m.r0c1;
            end else begin
                piv = PIV_W;
                t = one + a + b + c;
                comp[0] = m.r2c1 - m.r1c2;
                comp[1] = m.r0c2 - m.r2c0;
                comp[2] = m.r1c0 - m.r0c1;
            end
        end
        branch_hits[piv]++;
        r.degen = (t <= 0);
        for (int i = 0; i < 4; i++) begin
            if (r.degen) begin
                r.q[i] = '0;
            end else if (i == int'(piv)) begin
                r.q[i] = 16'(round_root(1, longint'(t) << FB, 32767));
            end else begin
                mag = (comp[i] < 0) ? -comp[i] : comp[i];
                k = round_root(t, (mag * mag) << FB, (comp[i] < 0) ? 32768 : 32767);
                r.q[i] = 16'((comp[i] < 0) ? -k : k);
            end
        end
        return r;
    endfunction

    function automatic quat_t quat_of(int x, int y, int z, int w, bit dg);
        quat_t r;
        r.q[0] = 16'(x);
        r.q[1] = 16'(y);
        r.q[2] = 16'(z);
        r.q[3] = 16'(w);
        r.degen = dg;
        return r;
    endfunction

    function automatic matrix_t diag(int a, int b, int c);
        matrix_t m;
        m = '0;
        m.r0c0 = 16'(a);
        m.r1c1 = 16'(b);
        m.r2c2 = 16'(c);
        return m;
    endfunction

    // Rotation about a random axis: elements built from a random unit quaternion.
    function automatic matrix_t random_rotation();
        real qx, qy, qz, qw, n, s;
        matrix_t m;
        qx = real'($urandom_range(0, 2000)) - 1000.0;
        qy = real'($urandom_range(0, 2000)) - 1000.0;
        qz = real'($urandom_range(0, 2000)) - 1000.0;
        qw = real'($urandom_range(0, 2000)) - 1000.0;
        n = $sqrt(qx * qx + qy * qy + qz * qz + qw * qw) + 1.0e-9;
        qx /= n; qy /= n; qz /= n; qw /= n;
        s = real'(1 << FB);
        m.r0c0 = 16'($rtoi(s * (1.0 - 2.0 * (qy * qy + qz * qz))));
        m.r1c1 = 16'($rtoi(s * (1.0 - 2.0 * (qx * qx + qz * qz))));
        m.r2c2 = 16'($rtoi(s * (1.0 - 2.0 * (qx * qx + qy * qy))));
        m.r1c0 = 16'($rtoi(s * 2.0 * (qx * qy + qz * qw)));
        m.r0c1 = 16'($rtoi(s * 2.0 * (qx * qy - qz * qw)));
        m.r2c0 = 16'($rtoi(s * 2.0 * (qx * qz - qy * qw)));
        m.r0c2 = 16'($rtoi(s * 2.0 * (qx * qz + qy * qw)));
        m.r2c1 = 16'($rtoi(s * 2.0 * (qy * qz + qx * qw)));
        m.r1c2 = 16'($rtoi(s * 2.0 * (qy * qz - qx * qw)));
        return m;
    endfunction

    function automatic matrix_t random_matrix();
        matrix_t m;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            m = random_rotation();
            // Nudge r0c1 off the ideal rotation.
            if (pick >= 4) m.r0c1 = m.r0c1 + 16'($urandom_range(0, 64)) - 16'd32;
        end else if (pick < 9) begin
            m = {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
        end else begin
            m = '0;
            m.r0c0 = 16'($urandom);
            m.r1c1 = 16'($urandom);
            m.r2c2 = 16'($urandom);
            m.r1c0 = 16'($urandom_range(0, 1)) ? 16'h7FFF : 16'h8000;
            m.r0c1 = m.r1c0;
        end
        return m;
    endfunction

    // Build the directed table: extremes, each branch, off-identity pivots, saturation.
    task automatic build_directed();
        matrix_t m;
        for (int i = 0; i < N_DIRECTED; i++) dir_has_exp[i] = 1'b0;
        // Identity: w pivot, w = 1.0, rest zero.
        dir_mat[0] = diag(16384, 16384, 16384);
        dir_exp[0] = quat_of(0, 0, 0, 16384, 0); dir_has_exp[0] = 1'b1;
        // 180 deg about x, y, z: pivot in x, y, z.
        dir_mat[1] = diag(16384, -16384, -16384);
        dir_exp[1] = quat_of(16384, 0, 0, 0, 0); dir_has_exp[1] = 1'b1;
        dir_mat[2] = diag(-16384, 16384, -16384);
        dir_exp[2] = quat_of(0, 16384, 0, 0, 0); dir_has_exp[2] = 1'b1;
        dir_mat[3] = diag(-16384, -16384, 16384);
        dir_exp[3] = quat_of(0, 0, 16384, 0, 0); dir_has_exp[3] = 1'b1;
        // All zero: w pivot with t = one, w = 0.5.
        dir_mat[4] = '0;
        dir_exp[4] = quat_of(0, 0, 0, 8192, 0); dir_has_exp[4] = 1'b1;
        // Lopsided diagonals: the pivot lands in z or y.
        dir_mat[5] = diag(-16384, 0, 0);
        dir_mat[6] = diag(0, -16384, 0);
        dir_mat[7] = diag(32767, 32767, -32768);
        // All ones, all minimum, all maximum and alternating bit patterns.
        dir_mat[8] = '1;
        dir_mat[9] = {9{16'h8000}};
        dir_mat[10] = {9{16'h7FFF}};
        dir_mat[11] = {9{16'h5555}};
        dir_mat[12] = {9{16'hAAAA}};
        // Full-scale off-diagonal elements with a z pivot.
        m = diag(-16383, 0, 0);
        m.r1c0 = 16'h7FFF; m.r0c1 = 16'h7FFF;
        m.r0c2 = 16'h7FFF; m.r2c0 = 16'h8000;
        dir_mat[13] = m;
        m = diag(-16383, 0, 0);
        m.r1c0 = 16'h8000; m.r0c1 = 16'h8000;
        m.r2c1 = 16'h8000; m.r1c2 = 16'h7FFF;
        dir_mat[14] = m;
        // Branch boundaries: a == b, a == -b, c == 0.
        dir_mat[15] = diag(100, 100, -1);
        dir_mat[16] = diag(-200, 200, 0);
        dir_mat[17] = diag(-201, 200, 0);
        dir_mat[18] = diag(-32768, 32767, 32767);
        dir_mat[19] = diag(32767, -32768, -32768);
        for (int i = 20; i < N_DIRECTED; i++) dir_mat[i] = random_rotation();
    endtask

    // Offer one request, then wait for it to be taken.
    task automatic send_matrix(matrix_t m, quat_t exp_q, bit use_exp);
        quat_t pred;
        pred = matrix_to_quat(m);
        if (use_exp) pred = exp_q;
        s_tdata  <= m;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quat_expected_q.push_back(pred);
        @(negedge aclk);
    endtask

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // Stimulus: reset, directed table, long receiver hold, drain pause, random stream.
    initial begin
        quat_t dummy;
        int gap;
        build_directed();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_matrix(dir_mat[i], dir_exp[i], dir_has_exp[i]);
            idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : 0);
        end
        // Hold the receiver off while requests keep coming, to fill the pipe.
        long_hold = 1'b1;
        for (int i = 0; i < 60; i++) send_matrix(random_matrix(), dummy, 1'b0);
        long_hold = 1'b0;
        // Pause until every pending result has come back.
        s_tvalid <= 1'b0;
        while (quat_expected_q.size() != 0) @(negedge aclk);
        for (int i = 0; i < N_RANDOM; i++) begin
            send_matrix(random_matrix(), dummy, 1'b0);
            gap = ((i / 150) % 2 == 1) ? 0 : $urandom_range(0, 12);
            if ($urandom_range(0, 2) == 0) gap = 0;
            idle_gap(gap);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // Receiver: random backpressure, plus a long hold counted here in cycles.
    initial begin
        int wait_n;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge aclk);
                m_tready <= 1'b1;
                while (long_hold) @(negedge aclk);
            end else begin
                wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (wait_n == 0 || cycle_count % 2000 > 1500) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (wait_n) @(negedge aclk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Check each accepted result against the oldest expectation.
    always @(posedge aclk) begin
        quat_t exp_q;
        logic signed [15:0] got;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (quat_expected_q.size() == 0) begin
                $display("%0t: result with nothing expected: data %h user %b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_q = quat_expected_q.pop_front();
                if (exp_q.degen) degen_count++;
                for (int i = 0; i < 4; i++) begin
                    got = m_tdata[16*i +: 16];
                    if (got !== exp_q.q[i]) begin
                        $display("%0t: component %0d expected %0d, actual %0d",
                                 $time, i, exp_q.q[i], got);
                        error_count++;
                    end
                end
                if (m_tuser[0] !== exp_q.degen) begin
                    $display("%0t: degenerate flag expected %b, actual %b",
                             $time, exp_q.degen, m_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Run control: timeout, drain, final verdict.
    initial begin
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= MAX_CYCLES) begin
                $display("Timeout after %0d cycles, %0d results pending",
                         cycle_count, quat_expected_q.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (stim_done && quat_expected_q.size() == 0) begin
                repeat (LATENCY + 5) @(posedge aclk);
                if (quat_expected_q.size() != 0) error_count++;
                $display("Checked %0d quaternions (%0d degenerate) under random stalls",
                         result_count, degen_count);
                $display("Pivot x/y/z/w hits %0d/%0d/%0d/%0d",
                         branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
                if (error_count == 0) begin
                    $display("Testbench completed without errors");
                end else begin
                    $display("Testbench completed WITH ERRORS");
                end
                $finish;
            end
        end
    end
endmodule

FILE: files.f
src/rmq_pkg.sv
src/rotation_matrix_to_quaternion.sv
dv/tb_rotation_matrix_to_quaternion.sv
